// ----- design/oul_pkg.sv -----
// package: shared types and constants for the ordered unique id list
`timescale 1ns / 1ps
package oul_pkg;

    // fixed payload widths
    localparam int unsigned ID_PORT_W  = 16;
    localparam int unsigned STATUS_W   = 3;
    localparam int unsigned COUNT_PORT_W = 6;

    // request opcodes
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // response status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_ADDED     = 3'd0,
        STS_DUPLICATE = 3'd1,
        STS_REMOVED   = 3'd2,
        STS_NOTFOUND  = 3'd3,
        STS_EMPTY     = 3'd4,
        STS_FULL      = 3'd5
    } t_status;

    // controller states
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // commit strobes from the controller to every cell
    typedef struct packed {
        logic shift;   // remove committed: cells at or past the hit take the neighbor
        logic append;  // append committed: the cell at the tail slot loads the key
    } t_cell_ctl;

endpackage

// ----- design/oul_if.sv -----
// interfaces: request and response channels
`timescale 1ns / 1ps
interface oul_req_if;
    logic                            valid;
    logic                            ready;
    logic                            opcode;
    logic [oul_pkg::ID_PORT_W-1:0]   item_id;

    modport source (output valid, output opcode, output item_id, input ready);
    modport sink   (input valid, input opcode, input item_id, output ready);
endinterface

interface oul_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [oul_pkg::STATUS_W-1:0]      status;
    logic [oul_pkg::COUNT_PORT_W-1:0]  entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink   (input valid, input status, input entry_count, output ready);
endinterface

// ----- design/oul_cell.sv -----
// cell: one list entry with its compare and shift-from-neighbor logic
`timescale 1ns / 1ps
module oul_cell #(
    parameter int unsigned ID_WIDTH = 16
) (
    input  logic                  i_clk,
    input  oul_pkg::t_cell_ctl    i_ctl,
    input  logic [ID_WIDTH-1:0]   i_key,
    input  logic                  i_valid,
    input  logic                  i_slot,
    input  logic                  i_hit,
    input  logic [ID_WIDTH-1:0]   i_next_id,
    output logic                  o_hit,
    output logic                  o_match,
    output logic [ID_WIDTH-1:0]   o_id
);
    import oul_pkg::*;

    logic [ID_WIDTH-1:0] r_id;
    logic [ID_WIDTH-1:0] n_id;

    // compare against the key, only for held entries
    assign o_match = i_valid && (r_id == i_key);
    // hit ripples toward the tail: set at and past the matching cell
    assign o_hit   = i_hit || o_match;
    assign o_id    = r_id;

    // close the gap or take the appended key
    always_comb begin
        n_id = r_id;
        if (i_ctl.shift && o_hit) begin
            n_id = i_next_id;
        end else if (i_ctl.append && i_slot) begin
            n_id = i_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id <= n_id;
    end

endmodule

// ----- design/ordered_unique_id_list_unit.sv -----
// top level: ordered list of unique ids built as a row of entry cells
//
//  channel | dir | modport | payload
//  i_req   | in  | sink    | opcode (1), item_id (16)
//  o_rsp   | out | source  | status (3), entry_count (6)
//
// a request is taken in one cycle and evaluated in the next, when all cells
// compare in parallel and commit the shift or append; no request is taken then.
// the response sits in an output register; a new request is taken once the
// previous response has left or is leaving. synchronous active-low reset
// clears the entry count and control; entry contents are not reset.
`timescale 1ns / 1ps
module ordered_unique_id_list_unit #(
    parameter int unsigned CAPACITY = 32,
    parameter int unsigned ID_WIDTH = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    oul_req_if.sink   i_req,
    oul_rsp_if.source o_rsp
);
    import oul_pkg::*;

    localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

    t_state                r_state;
    t_state                n_state;
    logic                  r_op;
    logic [ID_WIDTH-1:0]   r_key;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_status               r_status;
    t_status               n_status;
    logic [COUNT_PORT_W-1:0] r_out_count;
    logic [COUNT_PORT_W-1:0] n_out_count;

    t_cell_ctl             w_ctl;
    logic [CAPACITY-1:0]   w_hit;
    logic [CAPACITY-1:0]   w_match;
    logic [ID_WIDTH-1:0]   w_id [CAPACITY];
    logic [ID_WIDTH+ID_PORT_W-1:0] w_id_ext;
    logic [CNT_W+COUNT_PORT_W-1:0] w_cnt_ext;
    logic                  w_accept;
    logic                  w_found;
    logic                  w_full;
    logic                  w_empty;

    // handshake on the request side
    assign i_req.ready = (r_state == ST_IDLE) && (!r_out_valid || o_rsp.ready);
    assign w_accept    = i_req.valid && i_req.ready;

    // key keeps the low ID_WIDTH bits of the id
    assign w_id_ext = {{ID_WIDTH{1'b0}}, i_req.item_id};

    // request capture
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op  <= i_req.opcode;
            r_key <= w_id_ext[ID_WIDTH-1:0];
        end
    end

    // row of entry cells
    genvar k;
    generate
        for (k = 0; k < CAPACITY; k++) begin : g_cell
            logic w_hit_in;
            logic [ID_WIDTH-1:0] w_next;
            if (k == 0) begin : g_head
                assign w_hit_in = 1'b0;
            end else begin : g_body
                assign w_hit_in = w_hit[k-1];
            end
            if (k == CAPACITY - 1) begin : g_tail
                assign w_next = '0;
            end else begin : g_mid
                assign w_next = w_id[k+1];
            end
            oul_cell #(
                .ID_WIDTH (ID_WIDTH)
            ) u_cell (
                .i_clk     (i_clk),
                .i_ctl     (w_ctl),
                .i_key     (r_key),
                .i_valid   (r_count > CNT_W'(k)),
                .i_slot    (r_count == CNT_W'(k)),
                .i_hit     (w_hit_in),
                .i_next_id (w_next),
                .o_hit     (w_hit[k]),
                .o_match   (w_match[k]),
                .o_id      (w_id[k])
            );
        end
    endgenerate

    assign w_found = w_hit[CAPACITY-1];
    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    // controller: next state, commit strobes and response
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_out_count = r_out_count;
        w_ctl       = '0;
        w_cnt_ext   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state     = ST_IDLE;
                n_out_valid = 1'b1;
                if (r_op == OP_REMOVE) begin
                    if (w_empty) begin
                        n_status = STS_EMPTY;
                    end else if (!w_found) begin
                        n_status = STS_NOTFOUND;
                    end else begin
                        n_status    = STS_REMOVED;
                        n_count     = r_count - CNT_W'(1);
                        w_ctl.shift = 1'b1;
                    end
                end else begin
                    if (w_found) begin
                        n_status = STS_DUPLICATE;
                    end else if (w_full) begin
                        n_status = STS_FULL;
                    end else begin
                        n_status     = STS_ADDED;
                        n_count      = r_count + CNT_W'(1);
                        w_ctl.append = 1'b1;
                    end
                end
                w_cnt_ext   = {{COUNT_PORT_W{1'b0}}, n_count};
                n_out_count = w_cnt_ext[COUNT_PORT_W-1:0];
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // response payload register
    always_ff @(posedge i_clk) begin
        r_status    <= n_status;
        r_out_count <= n_out_count;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.entry_count = r_out_count;

    // ids are unique, so at most one held entry matches
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> $onehot0(w_match))
        else $error("more than one entry matches the key");

    // count never passes capacity
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // response register is free when a request is evaluated
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) |-> (!r_out_valid || o_rsp.ready))
        else $error("response register overwritten");

    // count moves only on an evaluation cycle
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> $stable(r_count))
        else $error("entry count changed while idle");

endmodule

// ----- verif/tb_ordered_unique_id_list_unit.sv -----
// testbench: ordered unique id list checked against its own list predictor
`timescale 1ns / 1ps
module tb_ordered_unique_id_list_unit;
    import oul_pkg::*;

    localparam int LIST_DEPTH   = 32;
    localparam int CLK_HALF     = 6;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int POOL_SIZE    = 40;
    localparam int SEG_ITEMS    = 60;
    localparam int SEGS_PER_PH  = 6;
    localparam int NUM_DIRECTED = 18;

    // random segment flavors, each with its own append share
    typedef enum int {SEG_FILL, SEG_DRAIN, SEG_MIXED} seg_kind_t;

    typedef struct {
        t_status          status;
        logic [5:0]       entry_count;
    } rsp_beat_t;

    typedef struct {
        logic             op;
        logic [15:0]      id;
        bit               typed;
        t_status          status;
        logic [5:0]       entry_count;
    } dir_row_t;

    logic i_clk;
    logic i_rst_n;

    oul_req_if req_if ();
    oul_rsp_if rsp_if ();

    ordered_unique_id_list_unit #(
        .CAPACITY(LIST_DEPTH),
        .ID_WIDTH(16)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    // predicted list contents and length
    logic [15:0] id_list [LIST_DEPTH];
    int          list_len;
    rsp_beat_t   rsp_expect_q [$];
    int          mismatch_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_req;
    bit          rsp_hold_on;
    logic [15:0] id_pool [POOL_SIZE];

    // directed rows: empty store, extremes, head/middle/tail removal, duplicate, not found
    dir_row_t dir_rows [NUM_DIRECTED] = '{
        '{OP_REMOVE, 16'h1234, 1'b1, STS_EMPTY,     6'd0},
        '{OP_APPEND, 16'h0000, 1'b1, STS_ADDED,     6'd1},
        '{OP_APPEND, 16'hFFFF, 1'b1, STS_ADDED,     6'd2},
        '{OP_APPEND, 16'h0000, 1'b1, STS_DUPLICATE, 6'd2},
        '{OP_APPEND, 16'h5555, 1'b1, STS_ADDED,     6'd3},
        '{OP_APPEND, 16'hAAAA, 1'b1, STS_ADDED,     6'd4},
        '{OP_REMOVE, 16'h1234, 1'b1, STS_NOTFOUND,  6'd4},
        '{OP_REMOVE, 16'hFFFF, 1'b1, STS_REMOVED,   6'd3},
        '{OP_APPEND, 16'hFFFF, 1'b1, STS_ADDED,     6'd4},
        '{OP_REMOVE, 16'h0000, 1'b1, STS_REMOVED,   6'd3},
        '{OP_APPEND, 16'h0000, 1'b1, STS_ADDED,     6'd4},
        '{OP_REMOVE, 16'h0000, 1'b1, STS_REMOVED,   6'd3},
        '{OP_REMOVE, 16'h5555, 1'b1, STS_REMOVED,   6'd2},
        '{OP_REMOVE, 16'hAAAA, 1'b1, STS_REMOVED,   6'd1},
        '{OP_REMOVE, 16'hFFFF, 1'b1, STS_REMOVED,   6'd0},
        '{OP_REMOVE, 16'hFFFF, 1'b1, STS_EMPTY,     6'd0},
        '{OP_APPEND, 16'h8001, 1'b0, STS_ADDED,     6'd0},
        '{OP_APPEND, 16'h7FFE, 1'b0, STS_ADDED,     6'd0}
    };

    // clock
    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // list predictor: append at tail unless held or full, remove closes the gap
    function automatic t_status apply_request(input logic op, input logic [15:0] id);
        int      hit;
        t_status st;
        hit = -1;
        for (int k = 0; k < list_len; k++)
            if (id_list[k] == id) hit = k;
        if (op == OP_APPEND) begin
            if (hit >= 0) begin
                st = STS_DUPLICATE;
            end else if (list_len >= LIST_DEPTH) begin
                st = STS_FULL;
            end else begin
                id_list[list_len] = id;
                list_len++;
                st = STS_ADDED;
            end
        end else begin
            if (list_len == 0) begin
                st = STS_EMPTY;
            end else if (hit < 0) begin
                st = STS_NOTFOUND;
            end else begin
                for (int k = hit; k < list_len - 1; k++)
                    id_list[k] = id_list[k + 1];
                list_len--;
                st = STS_REMOVED;
            end
        end
        return st;
    endfunction

    // offer one request beat, starting and ending at a falling edge
    task automatic send_request(input logic op, input logic [15:0] id, input bit typed,
                                input t_status typed_st, input logic [5:0] typed_cnt);
        rsp_beat_t beat;
        bit        taken;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.opcode  <= op;
        req_if.item_id <= id;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = (req_if.ready === 1'b1);
        end
        beat.status      = apply_request(op, id);
        beat.entry_count = list_len[5:0];
        if (typed) begin
            beat.status      = typed_st;
            beat.entry_count = typed_cnt;
        end
        rsp_expect_q.push_back(beat);
        @(negedge i_clk);
    endtask

    // pick an id: mostly held ones or the segment pool, some pure noise
    function automatic logic [15:0] pick_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (list_len > 0 && roll < 50)
            return id_list[$urandom_range(0, list_len - 1)];
        else if (roll < 80)
            return id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    // receiver stalls at random, or holds off completely during the hold window
    always @(negedge i_clk) begin
        rsp_if.ready <= !rsp_hold_on && ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // long receiver hold-off, counted in cycles here
    initial begin
        rsp_hold_on = 1'b0;
        wait (hold_req);
        @(posedge i_clk);
        rsp_hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        rsp_hold_on = 1'b0;
    end

    // response checker against the oldest expectation
    always @(posedge i_clk) begin
        rsp_beat_t exp_beat;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (rsp_expect_q.size() == 0) begin
                $error("response beat with nothing expected: status %0d entry_count %0d",
                       rsp_if.status, rsp_if.entry_count);
                mismatch_count++;
            end else begin
                exp_beat = rsp_expect_q.pop_front();
                if (rsp_if.status !== exp_beat.status) begin
                    $error("status: expected %0d (%s), actual %0d", exp_beat.status,
                           exp_beat.status.name(), rsp_if.status);
                    mismatch_count++;
                end
                if (rsp_if.entry_count !== exp_beat.entry_count) begin
                    $error("entry_count: expected %0d, actual %0d", exp_beat.entry_count,
                           rsp_if.entry_count);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("ordered_unique_id_list_unit: mismatch");
        $finish;
    end

    // stimulus
    initial begin
        seg_kind_t seg_kind;
        int        append_pct;
        logic      op;
        i_rst_n        = 1'b0;
        req_if.valid   = 1'b0;
        req_if.opcode  = OP_APPEND;
        req_if.item_id = '0;
        rsp_if.ready   = 1'b0;
        hold_req       = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        mismatch_count = 0;
        list_len       = 0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table
        foreach (dir_rows[r])
            send_request(dir_rows[r].op, dir_rows[r].id, dir_rows[r].typed,
                         dir_rows[r].status, dir_rows[r].entry_count);

        // random part: idle/stall phases, each of fill, drain or mixed segments, fill first
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            for (int sg = 0; sg < SEGS_PER_PH; sg++) begin
                if (ph == 0 && sg == 1) hold_req = 1'b1;
                seg_kind = seg_kind_t'($urandom_range(0, 2));
                if (sg == 0) seg_kind = SEG_FILL;
                case (seg_kind)
                    SEG_FILL:  append_pct = 85;
                    SEG_DRAIN: append_pct = 20;
                    default:   append_pct = 50;
                endcase
                foreach (id_pool[p]) id_pool[p] = 16'($urandom_range(0, 65535));
                for (int n = 0; n < SEG_ITEMS; n++) begin
                    op = ($urandom_range(0, 99) < append_pct) ? OP_APPEND : OP_REMOVE;
                    send_request(op, pick_id(), 1'b0, STS_ADDED, 6'd0);
                end
            end
        end
        req_if.valid <= 1'b0;

        // wait for every response, then a short tail for stray beats
        while (rsp_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("ordered_unique_id_list_unit: match");
        else
            $display("ordered_unique_id_list_unit: mismatch");
        $finish;
    end

endmodule

// ----- ordered_unique_id_list_unit.f -----
design/oul_pkg.sv
design/oul_if.sv
design/oul_cell.sv
design/ordered_unique_id_list_unit.sv
verif/tb_ordered_unique_id_list_unit.sv
